// ===== rtl/van_pkg.sv =====
// Shared widths, constants and types for the vector angle and normal block.
// Used by vector_angle_and_normal_top, van_checker and the testbench top.
package van_pkg;

  localparam int IN_W         = 32;
  localparam int DIFF_W       = 33;
  localparam int MAG_W        = 30;
  localparam int POS_W        = 6;
  localparam int SQ_W         = 2 * MAG_W;
  localparam int SUM_W        = 62;
  localparam int LEN_W        = SUM_W / 2;
  localparam int UNIT_FB      = 30;
  localparam int NUM_W        = MAG_W + UNIT_FB + 1;
  localparam int Q_W          = 31;
  localparam int U_W          = 32;
  localparam int PROD_W       = 64;
  localparam int N_W          = 16;
  localparam int D_W          = 32;
  localparam int RAD_W        = 62;
  localparam int S_W          = RAD_W / 2;
  localparam int CX_W         = 34;
  localparam int Z_W          = 32;
  localparam int ANG_W        = 16;
  localparam int CORDIC_STEPS = 20;

  localparam int LEN_SB_W = 3 * MAG_W + 4;
  localparam int DIV_SB_W = 7;
  localparam int ANG_SB_W = 1 + D_W + 3 * N_W;

  localparam logic signed [PROD_W-1:0] NRM_RND = 64'sh0000_2000_0000_0000;
  localparam logic signed [PROD_W-1:0] DOT_RND = 64'sh0000_0000_2000_0000;
  localparam logic signed [PROD_W-1:0] ONE_Q30 = 64'sd1073741824;
  localparam logic signed [PROD_W-1:0] N_MAX   = 64'sd32767;
  localparam logic signed [PROD_W-1:0] N_MIN   = -64'sd32768;
  localparam logic [RAD_W-1:0]         ONE_SQ_Q60 = 62'h1000_0000_0000_0000;
  localparam logic signed [Z_W-1:0]    DEG90_Q16  = 32'sd5898240;
  localparam logic signed [Z_W-1:0]    ANG_RND    = 32'sd128;
  localparam logic signed [Z_W-1:0]    DEG180_Q8  = 32'sd46080;

  // atan(2^-i) in degrees, Q15.16.
  localparam logic signed [Z_W-1:0] ATAN_DEG_Q16 [CORDIC_STEPS] = '{
    32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945, 32'sd234379,
    32'sd117304,  32'sd58666,   32'sd29335,  32'sd14668,  32'sd7334,
    32'sd3667,    32'sd1833,    32'sd917,    32'sd458,    32'sd229,
    32'sd115,     32'sd57,      32'sd29,     32'sd14,     32'sd7
  };

  typedef struct packed {
    logic signed [N_W-1:0] nx;
    logic signed [N_W-1:0] ny;
    logic signed [N_W-1:0] nz;
    logic [ANG_W-1:0]      angle;
    logic                  degen;
  } res_t;

endpackage

// ===== rtl/van_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband word alongside; depends on nothing else.
module van_sqrt #(
  parameter int VW = 62,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [VW-1:0]   in_val,
  input  logic [SW-1:0]   in_sb,
  output logic            out_vld,
  output logic [VW/2-1:0] out_root,
  output logic [SW-1:0]   out_sb
);
  localparam int RW = VW / 2;

  logic          src_vld  [RW];
  logic [VW-1:0] src_val  [RW];
  logic [RW:0]   src_rem  [RW];
  logic [RW-1:0] src_root [RW];
  logic [SW-1:0] src_sb   [RW];
  logic [RW:0]   nx_rem   [RW];
  logic [RW-1:0] nx_root  [RW];
  logic          r_vld    [RW];
  logic [VW-1:0] r_val    [RW];
  logic [RW:0]   r_rem    [RW];
  logic [RW-1:0] r_root   [RW];
  logic [SW-1:0] r_sb     [RW];

  always_comb begin
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    logic          ge;
    src_vld[0]  = in_vld;
    src_val[0]  = in_val;
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_sb[0]   = in_sb;
    for (int k = 1; k < RW; k++) begin
      src_vld[k]  = r_vld[k-1];
      src_val[k]  = r_val[k-1];
      src_rem[k]  = r_rem[k-1];
      src_root[k] = r_root[k-1];
      src_sb[k]   = r_sb[k-1];
    end
    for (int k = 0; k < RW; k++) begin
      // Bring down the next two radicand bits and try root*4+1.
      t          = {src_rem[k][RW-1:0], src_val[k][VW-1-2*k -: 2]};
      trial      = {src_root[k], 2'b01};
      ge         = (t >= trial);
      nx_rem[k]  = ge ? (RW+1)'(t - trial) : (RW+1)'(t);
      nx_root[k] = {src_root[k][RW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RW; k++) r_vld[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < RW; k++) r_vld[k] <= src_vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RW; k++) begin
        r_val[k]  <= src_val[k];
        r_rem[k]  <= nx_rem[k];
        r_root[k] <= nx_root[k];
        r_sb[k]   <= src_sb[k];
      end
    end
  end

  assign out_vld  = r_vld[RW-1];
  assign out_root = r_root[RW-1];
  assign out_sb   = r_sb[RW-1];

endmodule

// ===== rtl/van_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit QW bits; carries a sideband word; no dependencies.
module van_div #(
  parameter int NW = 61,
  parameter int DW = 31,
  parameter int QW = 31,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_sb,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_sb
);
  logic          src_vld [QW];
  logic [QW-1:0] src_lo  [QW];
  logic [DW-1:0] src_rem [QW];
  logic [DW-1:0] src_den [QW];
  logic [QW-1:0] src_q   [QW];
  logic [SW-1:0] src_sb  [QW];
  logic [DW-1:0] nx_rem  [QW];
  logic [QW-1:0] nx_q    [QW];
  logic          r_vld   [QW];
  logic [QW-1:0] r_lo    [QW];
  logic [DW-1:0] r_rem   [QW];
  logic [DW-1:0] r_den   [QW];
  logic [QW-1:0] r_q     [QW];
  logic [SW-1:0] r_sb    [QW];

  always_comb begin
    logic [DW:0] t;
    logic        ge;
    src_vld[0] = in_vld;
    src_lo[0]  = in_num[QW-1:0];
    src_rem[0] = DW'(in_num >> QW);
    src_den[0] = in_den;
    src_q[0]   = '0;
    src_sb[0]  = in_sb;
    for (int k = 1; k < QW; k++) begin
      src_vld[k] = r_vld[k-1];
      src_lo[k]  = r_lo[k-1];
      src_rem[k] = r_rem[k-1];
      src_den[k] = r_den[k-1];
      src_q[k]   = r_q[k-1];
      src_sb[k]  = r_sb[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      t         = {src_rem[k], src_lo[k][QW-1-k]};
      ge        = (t >= {1'b0, src_den[k]});
      nx_rem[k] = ge ? DW'(t - {1'b0, src_den[k]}) : DW'(t);
      nx_q[k]   = {src_q[k][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) r_vld[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < QW; k++) r_vld[k] <= src_vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        r_lo[k]  <= src_lo[k];
        r_rem[k] <= nx_rem[k];
        r_den[k] <= src_den[k];
        r_q[k]   <= nx_q[k];
        r_sb[k]  <= src_sb[k];
      end
    end
  end

  assign out_vld = r_vld[QW-1];
  assign out_quo = r_q[QW-1];
  assign out_sb  = r_sb[QW-1];

endmodule

// ===== rtl/vector_angle_and_normal_top.sv =====
// Throughput: one item per cycle while the skid buffer is empty; the length square roots,
// the six unit dividers and the angle square root each spend one register stage per result bit,
// the CORDIC one per step.
// A one-item skid buffer behind the output register stalls the whole pipeline when full.
// Reset (rst, synchronous) clears all valid bits and the output and skid flags.
module vector_angle_and_normal_top
  import van_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  origin_x,
  input  logic signed [IN_W-1:0]  origin_y,
  input  logic signed [IN_W-1:0]  origin_z,
  input  logic signed [IN_W-1:0]  first_x,
  input  logic signed [IN_W-1:0]  first_y,
  input  logic signed [IN_W-1:0]  first_z,
  input  logic signed [IN_W-1:0]  second_x,
  input  logic signed [IN_W-1:0]  second_y,
  input  logic signed [IN_W-1:0]  second_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [N_W-1:0]   normal_x,
  output logic signed [N_W-1:0]   normal_y,
  output logic signed [N_W-1:0]   normal_z,
  output logic [ANG_W-1:0]        angle_deg,
  output logic                    degenerate
);

  logic en;
  logic skid_full;
  res_t skid;
  res_t out_q;

  assign en       = !skid_full;
  assign in_ready = en;

  logic signed [IN_W-1:0] p_org [3];
  logic signed [IN_W-1:0] p_fst [3];
  logic signed [IN_W-1:0] p_snd [3];

  assign p_org[0] = origin_x;
  assign p_org[1] = origin_y;
  assign p_org[2] = origin_z;
  assign p_fst[0] = first_x;
  assign p_fst[1] = first_y;
  assign p_fst[2] = first_z;
  assign p_snd[0] = second_x;
  assign p_snd[1] = second_y;
  assign p_snd[2] = second_z;

  // Difference vectors.
  logic                     vld1;
  logic signed [DIFF_W-1:0] d1 [2][3];

  // Magnitudes, signs and largest magnitude.
  logic                     vld2;
  logic [DIFF_W-1:0]        mag_c [2][3];
  logic [DIFF_W-1:0]        mag2  [2][3];
  logic                     sgn2  [2][3];
  logic [DIFF_W-1:0]        max_c [2];
  logic [DIFF_W-1:0]        max2  [2];

  // Leading one of the largest magnitude.
  logic                     vld3;
  logic [POS_W-1:0]         pos_c [2];
  logic [POS_W-1:0]         pos3  [2];
  logic                     zero3 [2];
  logic [DIFF_W-1:0]        mag3  [2][3];
  logic                     sgn3  [2][3];

  // Block-scaled magnitudes.
  logic                     vld4;
  logic [DIFF_W-1:0]        sh_c  [2][3];
  logic [MAG_W-1:0]         smag4 [2][3];
  logic                     sgn4  [2][3];
  logic                     zero4 [2];

  // Squares.
  logic                     vld5;
  logic [SQ_W-1:0]          sq5   [2][3];
  logic [MAG_W-1:0]         smag5 [2][3];
  logic                     sgn5  [2][3];
  logic                     zero5 [2];

  // Sum of squares.
  logic                     vld6;
  logic [SUM_W-1:0]         sum6  [2];
  logic [LEN_SB_W-1:0]      len_sb_in  [2];
  logic [LEN_SB_W-1:0]      len_sb_out [2];
  logic [LEN_W-1:0]         len_root   [2];
  logic                     len_vld    [2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1[0][i] <= DIFF_W'(p_fst[i]) - DIFF_W'(p_org[i]);
        d1[1][i] <= DIFF_W'(p_snd[i]) - DIFF_W'(p_org[i]);
      end
    end
  end

  always_comb begin
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        mag_c[v][i] = d1[v][i][DIFF_W-1] ? DIFF_W'(-d1[v][i]) : DIFF_W'(d1[v][i]);
      end
      max_c[v] = (mag_c[v][0] > mag_c[v][1]) ? mag_c[v][0] : mag_c[v][1];
      if (mag_c[v][2] > max_c[v]) max_c[v] = mag_c[v][2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 2; v++) begin
        max2[v] <= max_c[v];
        for (int i = 0; i < 3; i++) begin
          mag2[v][i] <= mag_c[v][i];
          sgn2[v][i] <= d1[v][i][DIFF_W-1];
        end
      end
    end
  end

  always_comb begin
    for (int v = 0; v < 2; v++) begin
      pos_c[v] = '0;
      for (int b = 0; b < DIFF_W; b++) begin
        if (max2[v][b]) pos_c[v] = POS_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 2; v++) begin
        pos3[v]  <= pos_c[v];
        zero3[v] <= (max2[v] == '0);
        for (int i = 0; i < 3; i++) begin
          mag3[v][i] <= mag2[v][i];
          sgn3[v][i] <= sgn2[v][i];
        end
      end
    end
  end

  // Bring the largest magnitude into [2^29, 2^30); right shifts truncate.
  always_comb begin
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        if (pos3[v] >= POS_W'(MAG_W)) begin
          sh_c[v][i] = mag3[v][i] >> (pos3[v] - POS_W'(MAG_W - 1));
        end else begin
          sh_c[v][i] = mag3[v][i] << (POS_W'(MAG_W - 1) - pos3[v]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 2; v++) begin
        zero4[v] <= zero3[v];
        for (int i = 0; i < 3; i++) begin
          smag4[v][i] <= sh_c[v][i][MAG_W-1:0];
          sgn4[v][i]  <= sgn3[v][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 2; v++) begin
        zero5[v] <= zero4[v];
        for (int i = 0; i < 3; i++) begin
          sq5[v][i]   <= SQ_W'(smag4[v][i]) * SQ_W'(smag4[v][i]);
          smag5[v][i] <= smag4[v][i];
          sgn5[v][i]  <= sgn4[v][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 2; v++) begin
        sum6[v] <= SUM_W'(sq5[v][0]) + SUM_W'(sq5[v][1]) + SUM_W'(sq5[v][2]);
        len_sb_in[v] <= {zero5[v], sgn5[v][0], sgn5[v][1], sgn5[v][2],
                         smag5[v][0], smag5[v][1], smag5[v][2]};
      end
    end
  end

  for (genvar v = 0; v < 2; v++) begin : g_len
    van_sqrt #(
      .VW (SUM_W),
      .SW (LEN_SB_W)
    ) u_len (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_vld   (vld6),
      .in_val   (sum6[v]),
      .in_sb    (len_sb_in[v]),
      .out_vld  (len_vld[v]),
      .out_root (len_root[v]),
      .out_sb   (len_sb_out[v])
    );
  end

  // Rounded division set-up: (mag * 2^30 + len / 2) / len.
  logic                  vld7;
  logic [NUM_W-1:0]      num7 [2][3];
  logic [LEN_W-1:0]      den7 [2];
  logic [DIV_SB_W-1:0]   div_sb_in;
  logic [DIV_SB_W-1:0]   div_sb_out [6];
  logic [Q_W-1:0]        quo  [6];
  logic                  div_vld [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 2; v++) begin
        den7[v] <= len_root[v];
        for (int i = 0; i < 3; i++) begin
          num7[v][i] <= (NUM_W'(len_sb_out[v][MAG_W*(3-i)-1 -: MAG_W]) << UNIT_FB)
                        + NUM_W'(len_root[v] >> 1);
        end
      end
      div_sb_in <= {len_sb_out[0][LEN_SB_W-1] | len_sb_out[1][LEN_SB_W-1],
                    len_sb_out[0][3*MAG_W+2], len_sb_out[0][3*MAG_W+1],
                    len_sb_out[0][3*MAG_W],
                    len_sb_out[1][3*MAG_W+2], len_sb_out[1][3*MAG_W+1],
                    len_sb_out[1][3*MAG_W]};
    end
  end

  for (genvar j = 0; j < 6; j++) begin : g_div
    van_div #(
      .NW (NUM_W),
      .DW (LEN_W),
      .QW (Q_W),
      .SW (DIV_SB_W)
    ) u_div (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (vld7),
      .in_num  (num7[j/3][j%3]),
      .in_den  (den7[j/3]),
      .in_sb   (div_sb_in),
      .out_vld (div_vld[j]),
      .out_quo (quo[j]),
      .out_sb  (div_sb_out[j])
    );
  end

  // Signed unit vectors, Q1.30.
  logic                    vld8;
  logic signed [U_W-1:0]   u8 [6];
  logic                    degen8;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        u8[j] <= div_sb_out[0][5-j] ? -U_W'(quo[j]) : U_W'(quo[j]);
      end
      degen8 <= div_sb_out[0][DIV_SB_W-1];
    end
  end

  // Products: cross terms, then the three dot terms. ua is u8[0..2], ub is u8[3..5].
  logic                     vld9;
  logic signed [PROD_W-1:0] pr9 [9];
  logic                     degen9;

  always_ff @(posedge clk) begin
    if (en) begin
      pr9[0] <= u8[1] * u8[5];
      pr9[1] <= u8[2] * u8[4];
      pr9[2] <= u8[2] * u8[3];
      pr9[3] <= u8[0] * u8[5];
      pr9[4] <= u8[0] * u8[4];
      pr9[5] <= u8[1] * u8[3];
      pr9[6] <= u8[0] * u8[3];
      pr9[7] <= u8[1] * u8[4];
      pr9[8] <= u8[2] * u8[5];
      degen9 <= degen8;
    end
  end

  logic                     vld10;
  logic signed [PROD_W-1:0] cr10 [3];
  logic signed [PROD_W-1:0] dot10;
  logic                     degen10;

  always_ff @(posedge clk) begin
    if (en) begin
      cr10[0] <= pr9[0] - pr9[1];
      cr10[1] <= pr9[2] - pr9[3];
      cr10[2] <= pr9[4] - pr9[5];
      dot10   <= pr9[6] + pr9[7] + pr9[8];
      degen10 <= degen9;
    end
  end

  // Round the normal to Q2.14 and the dot product to Q1.30, both saturated.
  logic                     vld11;
  logic signed [N_W-1:0]    n11 [3];
  logic signed [D_W-1:0]    d11;
  logic                     degen11;
  logic signed [PROD_W-1:0] nr_c [3];
  logic signed [PROD_W-1:0] dr_c;
  logic signed [N_W-1:0]    ns_c [3];
  logic signed [D_W-1:0]    ds_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nr_c[k] = (cr10[k] + NRM_RND) >>> 46;
      if (nr_c[k] > N_MAX) begin
        ns_c[k] = N_W'(N_MAX);
      end else if (nr_c[k] < N_MIN) begin
        ns_c[k] = N_W'(N_MIN);
      end else begin
        ns_c[k] = nr_c[k][N_W-1:0];
      end
    end
    dr_c = (dot10 + DOT_RND) >>> 30;
    if (dr_c > ONE_Q30) begin
      ds_c = D_W'(ONE_Q30);
    end else if (dr_c < -ONE_Q30) begin
      ds_c = D_W'(-ONE_Q30);
    end else begin
      ds_c = dr_c[D_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) n11[k] <= ns_c[k];
      d11     <= ds_c;
      degen11 <= degen10;
    end
  end

  // Sine term: sqrt(2^60 - d*d).
  logic                     vld12;
  logic [RAD_W-1:0]         dd12;
  logic signed [PROD_W-1:0] dd_c;
  logic signed [N_W-1:0]    n12 [3];
  logic signed [D_W-1:0]    d12;
  logic                     degen12;

  assign dd_c = d11 * d11;

  always_ff @(posedge clk) begin
    if (en) begin
      dd12    <= dd_c[RAD_W-1:0];
      for (int k = 0; k < 3; k++) n12[k] <= n11[k];
      d12     <= d11;
      degen12 <= degen11;
    end
  end

  logic                vld13;
  logic [RAD_W-1:0]    rad13;
  logic [ANG_SB_W-1:0] ang_sb_in;
  logic [ANG_SB_W-1:0] ang_sb_out;
  logic [S_W-1:0]      s_root;
  logic                s_vld;

  always_ff @(posedge clk) begin
    if (en) begin
      rad13     <= ONE_SQ_Q60 - dd12;
      ang_sb_in <= {degen12, d12, n12[0], n12[1], n12[2]};
    end
  end

  van_sqrt #(
    .VW (RAD_W),
    .SW (ANG_SB_W)
  ) u_sin (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (vld13),
    .in_val   (rad13),
    .in_sb    (ang_sb_in),
    .out_vld  (s_vld),
    .out_root (s_root),
    .out_sb   (ang_sb_out)
  );

  // Vectoring CORDIC; stage zero holds the quadrant-corrected start vector.
  logic                  c_vld [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] c_x  [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] c_y  [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  c_z  [CORDIC_STEPS+1];
  logic [ANG_SB_W-1:0]    c_sb [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] cx_next [CORDIC_STEPS];
  logic signed [CX_W-1:0] cy_next [CORDIC_STEPS];
  logic signed [Z_W-1:0]  cz_next [CORDIC_STEPS];
  logic signed [D_W-1:0]  d_s;
  logic signed [CX_W-1:0] x0_c;
  logic signed [CX_W-1:0] y0_c;
  logic signed [Z_W-1:0]  z0_c;

  assign d_s = ang_sb_out[ANG_SB_W-2 -: D_W];

  always_comb begin
    // A negative cosine is turned by -90 degrees first.
    if (d_s < 0) begin
      x0_c = CX_W'(s_root);
      y0_c = -CX_W'(d_s);
      z0_c = DEG90_Q16;
    end else begin
      x0_c = CX_W'(d_s);
      y0_c = CX_W'(s_root);
      z0_c = '0;
    end
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      if (c_y[k] >= 0) begin
        cx_next[k] = c_x[k] + (c_y[k] >>> k);
        cy_next[k] = c_y[k] - (c_x[k] >>> k);
        cz_next[k] = c_z[k] + ATAN_DEG_Q16[k];
      end else begin
        cx_next[k] = c_x[k] - (c_y[k] >>> k);
        cy_next[k] = c_y[k] + (c_x[k] >>> k);
        cz_next[k] = c_z[k] - ATAN_DEG_Q16[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_x[0]  <= x0_c;
      c_y[0]  <= y0_c;
      c_z[0]  <= z0_c;
      c_sb[0] <= ang_sb_out;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        c_x[k+1]  <= cx_next[k];
        c_y[k+1]  <= cy_next[k];
        c_z[k+1]  <= cz_next[k];
        c_sb[k+1] <= c_sb[k];
      end
    end
  end

  // Final rounding of the angle to Q8.8 and the zero-length override.
  logic                  vld15;
  res_t                  res15;
  logic signed [Z_W-1:0] zr_c;
  logic [ANG_W-1:0]      ang_c;
  res_t                  res_c;

  always_comb begin
    zr_c = (c_z[CORDIC_STEPS] + ANG_RND) >>> 8;
    if (zr_c < 0) begin
      ang_c = '0;
    end else if (zr_c > DEG180_Q8) begin
      ang_c = ANG_W'(DEG180_Q8);
    end else begin
      ang_c = zr_c[ANG_W-1:0];
    end
    if (c_sb[CORDIC_STEPS][ANG_SB_W-1]) begin
      res_c = '{nx: '0, ny: '0, nz: '0, angle: '0, degen: 1'b1};
    end else begin
      res_c.nx    = c_sb[CORDIC_STEPS][3*N_W-1 -: N_W];
      res_c.ny    = c_sb[CORDIC_STEPS][2*N_W-1 -: N_W];
      res_c.nz    = c_sb[CORDIC_STEPS][N_W-1:0];
      res_c.angle = ang_c;
      res_c.degen = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) res15 <= res_c;
  end

  // Valid bits of the stages outside the submodules.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1  <= 1'b0;
      vld2  <= 1'b0;
      vld3  <= 1'b0;
      vld4  <= 1'b0;
      vld5  <= 1'b0;
      vld6  <= 1'b0;
      vld7  <= 1'b0;
      vld8  <= 1'b0;
      vld9  <= 1'b0;
      vld10 <= 1'b0;
      vld11 <= 1'b0;
      vld12 <= 1'b0;
      vld13 <= 1'b0;
      vld15 <= 1'b0;
      for (int k = 0; k <= CORDIC_STEPS; k++) c_vld[k] <= 1'b0;
    end else if (en) begin
      vld1  <= in_valid;
      vld2  <= vld1;
      vld3  <= vld2;
      vld4  <= vld3;
      vld5  <= vld4;
      vld6  <= vld5;
      vld7  <= len_vld[0] & len_vld[1];
      vld8  <= div_vld[0] & div_vld[1] & div_vld[2] & div_vld[3] & div_vld[4] & div_vld[5];
      vld9  <= vld8;
      vld10 <= vld9;
      vld11 <= vld10;
      vld12 <= vld11;
      vld13 <= vld12;
      c_vld[0] <= s_vld;
      for (int k = 0; k < CORDIC_STEPS; k++) c_vld[k+1] <= c_vld[k];
      vld15 <= c_vld[CORDIC_STEPS];
    end
  end

  // Output register with a one-item skid buffer; the pipeline only moves while the
  // skid buffer is empty, so at most one item can arrive after the output stalls.
  logic arrive;

  assign arrive = en && vld15;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= arrive;
      end
    end else if (arrive) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_q <= skid_full ? skid : res15;
    end else if (arrive) begin
      skid <= res15;
    end
  end

  assign normal_x   = out_q.nx;
  assign normal_y   = out_q.ny;
  assign normal_z   = out_q.nz;
  assign angle_deg  = out_q.angle;
  assign degenerate = out_q.degen;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid buffer holds an item while the output register is empty");

  a_skid_kept: assert property (@(posedge clk) disable iff (rst)
    skid_full && !out_ready |=> skid_full)
    else $error("skid item dropped while the output is stalled");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0
                                && angle_deg == '0)
    else $error("zero-length item carries a nonzero result");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> angle_deg <= ANG_W'(DEG180_Q8))
    else $error("angle above 180 degrees");
`endif

endmodule

// ===== tb/van_checker.sv =====
// Checker for vector_angle_and_normal_top: predicts each result from the accepted points
// and compares every delivered result with the oldest prediction. Depends on van_pkg.
`timescale 1ns / 100ps
module van_checker
  import van_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic signed [IN_W-1:0] origin_x,
  input  logic signed [IN_W-1:0] origin_y,
  input  logic signed [IN_W-1:0] origin_z,
  input  logic signed [IN_W-1:0] first_x,
  input  logic signed [IN_W-1:0] first_y,
  input  logic signed [IN_W-1:0] first_z,
  input  logic signed [IN_W-1:0] second_x,
  input  logic signed [IN_W-1:0] second_y,
  input  logic signed [IN_W-1:0] second_z,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic signed [N_W-1:0]  normal_x,
  input  logic signed [N_W-1:0]  normal_y,
  input  logic signed [N_W-1:0]  normal_z,
  input  logic [ANG_W-1:0]       angle_deg,
  input  logic                   degenerate,
  output int                     errors,
  output int                     pending
);

  localparam longint ONE30 = 64'sd1 <<< 30;
  localparam longint ATAN_TBL [20] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  res_t expected_q[$];

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits = bits >> 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v = v - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  // Block-scales a difference vector and divides by its length; 0 for the zero vector.
  function automatic bit unit_vec(input longint c [3], output longint u [3]);
    longint unsigned mag [3];
    longint unsigned m, sum, len, q;
    int rs, ls;
    m = 0;
    sum = 0;
    rs = 0;
    ls = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (c[i] < 0) ? -c[i] : c[i];
      if (mag[i] > m) m = mag[i];
      u[i] = 0;
    end
    if (m == 0) return 0;
    while (m >= (64'd1 << 30)) begin m = m >> 1; rs++; end
    while (m < (64'd1 << 29)) begin m = m << 1; ls++; end
    for (int i = 0; i < 3; i++) begin
      mag[i] = (mag[i] >> rs) << ls;
      sum += mag[i] * mag[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 30) + (len >> 1)) / len;
      u[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic logic signed [N_W-1:0] round_q2_14(input longint v);
    longint r;
    r = (v + (64'sd1 <<< 45)) >>> 46;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[N_W-1:0];
  endfunction

  function automatic logic [ANG_W-1:0] cordic_angle(input longint d);
    longint x, y, z, nx, s;
    s = longint'(int_sqrt(longint'(ONE30 * ONE30 - d * d)));
    z = 0;
    if (d < 0) begin
      x = s;
      y = -d;
      z = 90 * 65536;
    end else begin
      x = d;
      y = s;
    end
    for (int i = 0; i < 20; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_TBL[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_TBL[i];
      end
      x = nx;
    end
    z = (z + 128) >>> 8;
    if (z < 0) z = 0;
    if (z > 46080) z = 46080;
    return z[ANG_W-1:0];
  endfunction

  function automatic res_t predict_normal_angle(input longint p [9]);
    longint a [3], b [3], ua [3], ub [3];
    longint dot;
    res_t r;
    for (int i = 0; i < 3; i++) begin
      a[i] = p[3+i] - p[i];
      b[i] = p[6+i] - p[i];
    end
    r = '0;
    if (!unit_vec(a, ua) || !unit_vec(b, ub)) begin
      r.degen = 1'b1;
      return r;
    end
    r.nx = round_q2_14(ua[1] * ub[2] - ua[2] * ub[1]);
    r.ny = round_q2_14(ua[2] * ub[0] - ua[0] * ub[2]);
    r.nz = round_q2_14(ua[0] * ub[1] - ua[1] * ub[0]);
    dot = ua[0] * ub[0] + ua[1] * ub[1] + ua[2] * ub[2];
    dot = (dot + (64'sd1 <<< 29)) >>> 30;
    if (dot > ONE30) dot = ONE30;
    if (dot < -ONE30) dot = -ONE30;
    r.angle = cordic_angle(dot);
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    longint pts [9];
    res_t want, got;
    if (rst) begin
      errors <= 0;
    end
    if (!rst && in_valid && in_ready) begin
      pts = '{origin_x, origin_y, origin_z, first_x, first_y, first_z,
              second_x, second_y, second_z};
      expected_q.push_back(predict_normal_angle(pts));
    end
    if (!rst && out_valid && out_ready) begin
      got = '{normal_x, normal_y, normal_z, angle_deg, degenerate};
      if (expected_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result item %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("mismatch: exp n=%0d,%0d,%0d ang=%0d dg=%0b got n=%0d,%0d,%0d ang=%0d dg=%0b",
                     want.nx, want.ny, want.nz, want.angle, want.degen,
                     got.nx, got.ny, got.nz, got.angle, got.degen);
        end
      end
    end
  end

endmodule

// ===== tb/tb_vector_angle_and_normal_top.sv =====
// Top of the testbench for vector_angle_and_normal_top: clock, reset, point stimulus with
// bursty sending and a stalling receiver, and the verdict. Depends on van_pkg and van_checker.
`timescale 1ns / 100ps
module tb_vector_angle_and_normal_top;
  import van_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid, degenerate;
  logic signed [IN_W-1:0] pt [9] = '{default: '0};
  logic signed [N_W-1:0] normal_x, normal_y, normal_z;
  logic [ANG_W-1:0] angle_deg;
  logic took = 1'b0;
  int errors, pending;
  int ready_mode = 0;
  int ready_cnt = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vector_angle_and_normal_top DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .origin_x(pt[0]), .origin_y(pt[1]), .origin_z(pt[2]),
    .first_x(pt[3]), .first_y(pt[4]), .first_z(pt[5]),
    .second_x(pt[6]), .second_y(pt[7]), .second_z(pt[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .angle_deg(angle_deg), .degenerate(degenerate)
  );

  van_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .origin_x(pt[0]), .origin_y(pt[1]), .origin_z(pt[2]),
    .first_x(pt[3]), .first_y(pt[4]), .first_z(pt[5]),
    .second_x(pt[6]), .second_y(pt[7]), .second_z(pt[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .angle_deg(angle_deg), .degenerate(degenerate),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) took <= in_valid && in_ready;

  // Each time ready_cnt wraps, the receiver picks at random between always ready, half and mostly stalled.
  always @(negedge clk) begin
    if (ready_cnt == 63) ready_mode <= $urandom_range(0, 2);
    ready_cnt <= (ready_cnt + 1) % 64;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Called at a falling edge; returns at the falling edge after the item was taken.
  task automatic send_points(input logic signed [IN_W-1:0] v [9]);
    pt = v;
    in_valid = 1'b1;
    do @(negedge clk); while (!took);
  endtask

  task automatic send_pair(input logic signed [IN_W-1:0] o [3],
                           input logic signed [IN_W-1:0] a [3],
                           input logic signed [IN_W-1:0] b [3]);
    logic signed [IN_W-1:0] v [9];
    v = '{o[0], o[1], o[2], a[0], a[1], a[2], b[0], b[1], b[2]};
    send_points(v);
  endtask

  function automatic logic signed [IN_W-1:0] rnd_coord(input int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
  endfunction

  initial begin
    logic signed [IN_W-1:0] o [3], a [3], b [3];
    int kind, burst, gap;
    localparam logic signed [IN_W-1:0] MX = 32'sh7FFF_FFFF;
    localparam logic signed [IN_W-1:0] MN = 32'sh8000_0000;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    // Zero-length vectors: first, second and both.
    send_pair('{5, 6, 7}, '{5, 6, 7}, '{9, 1, 2});
    send_pair('{5, 6, 7}, '{1, 2, 3}, '{5, 6, 7});
    send_pair('{MN, MX, 0}, '{MN, MX, 0}, '{MN, MX, 0});
    // Same direction, opposite direction and right angles.
    send_pair('{0, 0, 0}, '{65536, 0, 0}, '{131072, 0, 0});
    send_pair('{0, 0, 0}, '{65536, 0, 0}, '{-65536, 0, 0});
    send_pair('{0, 0, 0}, '{65536, 0, 0}, '{0, 65536, 0});
    send_pair('{0, 0, 0}, '{0, 0, 1}, '{1, 0, 0});
    send_pair('{10, 10, 10}, '{10, 11, 10}, '{10, 10, 9});
    // Extreme differences that need the widest right shift.
    send_pair('{MN, MN, MN}, '{MX, MX, MX}, '{MX, MN, MX});
    send_pair('{MX, MX, MX}, '{MN, MN, MN}, '{MN, MX, MN});
    send_pair('{MN, 0, MX}, '{MX, 0, MN}, '{MN, MX, MX});
    send_pair('{-1, -1, -1}, '{MX, -1, -1}, '{-1, -1, MN});
    // Single-LSB vectors that need the widest left shift, then one alternating-bit pattern triple.
    send_pair('{0, 0, 0}, '{1, 1, 1}, '{-1, -1, -1});
    send_pair('{0, 0, 0}, '{1, 0, 0}, '{1, 1, 0});
    send_pair('{0, 0, 0}, '{-1, 0, 0}, '{-1, 1, 0});
    send_pair('{MN, MN, MN}, '{MN + 1, MN, MN}, '{MN, MN + 1, MN});
    send_pair('{32'sh5555_5555, 32'shAAAA_AAAA, 0}, '{32'shAAAA_AAAA, 0, 32'sh5555_5555},
              '{0, 32'sh5555_5555, 32'shAAAA_AAAA});
    in_valid = 1'b0;
    // Random bursts: mostly general triples, some small or collinear, some degenerate.
    for (int n = 0; n < 450; ) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst; j++) begin
        kind = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
          o[i] = rnd_coord(kind);
          a[i] = rnd_coord(kind);
          b[i] = rnd_coord(kind);
        end
        case ($urandom_range(0, 15))
          0: a = o;
          1: b = o;
          2: for (int i = 0; i < 3; i++) b[i] = o[i] + 2 * (a[i] - o[i]);
          3: for (int i = 0; i < 3; i++) b[i] = o[i] - (a[i] - o[i]);
          default: ;
        endcase
        send_pair(o, a, b);
        n++;
      end
      in_valid = 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/van_pkg.sv
rtl/van_sqrt.sv
rtl/van_div.sv
rtl/vector_angle_and_normal_top.sv
tb/van_checker.sv
tb/tb_vector_angle_and_normal_top.sv
